/* rtl/core/iht_pkg.sv */
// ----------------------------------------------------------------------------
// iht_pkg
// Shared types and constants of the identity hysteresis tracker.
// ----------------------------------------------------------------------------
package iht_pkg;

  // gallery size and counter width
  localparam int MaxIds    = 1024;
  localparam int CountBits = 24;

  // stability divider: 16 fraction bits plus one integer bit
  localparam int DivSteps  = 17;
  localparam int StepW     = $clog2(DivSteps);

  // configuration register indexes
  localparam logic [2:0] REG_SCORE_ON    = 3'd0;
  localparam logic [2:0] REG_SCORE_OFF   = 3'd1;
  localparam logic [2:0] REG_EMA_WEIGHT  = 3'd2;
  localparam logic [2:0] REG_STABLE_MS   = 3'd3;
  localparam logic [2:0] REG_SAVE_PERIOD = 3'd4;
  localparam logic [2:0] REG_SAVE_LIMIT  = 3'd5;
  localparam logic [2:0] REG_RUN_MODE    = 3'd6;

  // run modes
  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_REC  = 2'd1;
  localparam logic [1:0] MODE_ACQ  = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_IDLE    = 2'd0;
  localparam logic [1:0] STAT_UNKNOWN = 2'd1;
  localparam logic [1:0] STAT_KNOWN   = 2'd2;

  // configuration registers
  typedef struct packed {
    logic signed [15:0] score_on;
    logic signed [15:0] score_off;
    logic [15:0]        ema_weight;
    logic [15:0]        stable_ms;
    logic [15:0]        save_period_ms;
    logic [5:0]         save_limit;
    logic [1:0]         run_mode;
  } cfg_t;

  // command from front to back
  typedef struct packed {
    logic               is_idle;
    logic [31:0]        lock_ident;
    logic signed [10:0] cand_id;
    logic               cand_valid;
    logic signed [15:0] cand_score;
    logic [31:0]        stamp_ms;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [1:0]         status;
    logic signed [10:0] pred_id;
    logic signed [15:0] smooth_score;
    logic signed [15:0] frame_score;
    logic [15:0]        stability;
    logic [31:0]        episode_lock;
    logic               save_now;
    logic [5:0]         save_index;
  } res_t;

endpackage

/* rtl/core/iht_front.sv */
// ----------------------------------------------------------------------------
// iht_front
// Accepts tracking updates, applies the mode, lock and frame gates and
// issues idle or run commands to the queue.
// ----------------------------------------------------------------------------
module iht_front import iht_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        accept_i,
  input  logic        locked_i,
  input  logic        has_box_i,
  input  logic [15:0] lock_age_ms_i,
  input  logic [31:0] lock_ident_i,
  input  logic        frame_ok_i,
  input  logic [31:0] frame_seq_i,
  input  logic        embed_ok_i,
  input  logic [10:0] cand_id_i,
  input  logic [15:0] cand_score_i,
  input  logic [31:0] stamp_ms_i,
  input  logic        gallery_nonempty_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  logic        idle_rep_q, idle_rep_d;
  logic [31:0] last_frame_q, last_frame_d;
  logic        idle_mode;
  logic        lock_good;

  // gate decisions
  assign idle_mode = (cfg_i.run_mode == MODE_OFF) || (cfg_i.run_mode == MODE_RSVD) ||
                     !gallery_nonempty_i;
  assign lock_good = locked_i && has_box_i && (lock_age_ms_i >= cfg_i.stable_ms) &&
                     frame_ok_i && (frame_seq_i != last_frame_q);

  always_comb begin
    idle_rep_d   = idle_rep_q;
    last_frame_d = last_frame_q;
    push_o       = 1'b0;
    if (accept_i) begin
      if (idle_mode) begin
        if (!idle_rep_q) begin
          idle_rep_d = 1'b1;
          push_o     = 1'b1;
        end
      end else begin
        idle_rep_d = 1'b0;
        if (lock_good) begin
          last_frame_d = frame_seq_i;
          push_o       = embed_ok_i;
        end
      end
    end
  end

  // command payload
  always_comb begin
    cmd_o.is_idle    = idle_mode;
    cmd_o.lock_ident = lock_ident_i;
    cmd_o.cand_id    = cand_id_i;
    cmd_o.cand_valid = !cand_id_i[10] && ({21'b0, cand_id_i} < 32'(MaxIds));
    cmd_o.cand_score = cand_score_i;
    cmd_o.stamp_ms   = stamp_ms_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_rep_q   <= 1'b0;
      last_frame_q <= '0;
    end else begin
      idle_rep_q   <= idle_rep_d;
      last_frame_q <= last_frame_d;
    end
  end

endmodule

/* rtl/core/iht_queue.sv */
// ----------------------------------------------------------------------------
// iht_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module iht_queue import iht_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign cmd_o   = entry_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

/* rtl/core/iht_back.sv */
// ----------------------------------------------------------------------------
// iht_back
// Episode tracking, score smoothing, identity hysteresis, save throttle and
// serial stability divider; holds the result until it is taken.
// ----------------------------------------------------------------------------
module iht_back import iht_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic empty_i,
  input  cmd_t cmd_i,
  output logic pop_o,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  typedef enum logic [4:0] {
    ST_WAIT = 5'b00001,
    ST_EMA  = 5'b00010,
    ST_HYS  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } back_state_e;

  localparam logic [CountBits-1:0] CountMax = '1;

  back_state_e          state_q, state_d;
  logic                 ep_open_q;
  logic [31:0]          ep_ident_q;
  logic signed [15:0]   ema_q;
  logic signed [10:0]   held_q;
  logic [CountBits-1:0] frames_q, known_q;
  logic [5:0]           saved_q;
  logic [31:0]          last_save_q;
  logic                 saved_once_q;
  cmd_t                 cur_q;
  logic signed [33:0]   prod_q;
  logic [CountBits:0]   rem_q;
  logic [DivSteps-1:0]  quo_q;
  logic [StepW-1:0]     step_q;
  logic                 save_now_q;
  logic [5:0]           save_idx_q;
  res_t                 res_q;

  logic                 new_ep;
  logic signed [33:0]   ema_sum;
  logic signed [17:0]   ema_raw;
  logic signed [15:0]   ema_sat;
  logic signed [10:0]   held_next;
  logic [CountBits-1:0] known_next;
  logic                 do_save;
  logic [31:0]          elapsed;
  logic [CountBits:0]   rem_sh;
  logic                 rem_ge;
  res_t                 idle_res;
  res_t                 run_res;

  assign new_ep      = !ep_open_q || (cmd_i.lock_ident != ep_ident_q);
  assign pop_o       = (state_q == ST_WAIT) && !empty_i;
  assign res_valid_o = (state_q == ST_OUT);
  assign res_o       = res_q;

  // smoothing: ema + w*(score-ema), rounded to nearest and saturated
  assign ema_sum = {{2{ema_q[15]}}, ema_q, 16'b0} + prod_q + 34'sd32768;
  assign ema_raw = ema_sum[33:16];
  always_comb begin
    if (ema_raw > 18'sd32767)       ema_sat = 16'sh7fff;
    else if (ema_raw < -18'sd32768) ema_sat = 16'sh8000;
    else                            ema_sat = ema_raw[15:0];
  end

  // four-branch two-threshold hysteresis
  always_comb begin
    held_next = held_q;
    if (held_q[10]) begin
      if (ema_q >= cfg_i.score_on && cur_q.cand_valid) held_next = cur_q.cand_id;
    end else if (cur_q.cand_valid && cur_q.cand_id == held_q) begin
      if (ema_q < cfg_i.score_off) held_next = '1;
    end else if (ema_q >= cfg_i.score_on && cur_q.cand_valid) begin
      held_next = cur_q.cand_id;
    end else if (ema_q < cfg_i.score_off) begin
      held_next = '1;
    end
  end

  assign known_next = (!held_next[10] && known_q != CountMax) ? known_q + 1'b1 : known_q;

  // save throttle
  assign elapsed = cur_q.stamp_ms - last_save_q;
  assign do_save = (cfg_i.run_mode == MODE_ACQ) && (saved_q < cfg_i.save_limit) &&
                   (!saved_once_q || elapsed >= {16'b0, cfg_i.save_period_ms});

  // restoring divider step, no shift on the integer bit
  assign rem_sh = (step_q == '0) ? rem_q : {rem_q[CountBits-1:0], 1'b0};
  assign rem_ge = rem_sh >= {1'b0, frames_q};

  // idle result: no identity, everything else zero
  always_comb begin
    idle_res         = '0;
    idle_res.status  = STAT_IDLE;
    idle_res.pred_id = '1;
  end

  // tracking result, taken on the last divider step
  always_comb begin
    run_res              = '0;
    run_res.status       = held_q[10] ? STAT_UNKNOWN : STAT_KNOWN;
    run_res.pred_id      = held_q;
    run_res.smooth_score = ema_q;
    run_res.frame_score  = cur_q.cand_score;
    run_res.episode_lock = ep_ident_q;
    run_res.save_now     = save_now_q;
    run_res.save_index   = save_idx_q;
    run_res.stability    = quo_q[DivSteps-2] ? 16'hffff : {quo_q[14:0], rem_ge};
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_WAIT: begin
        if (!empty_i) begin
          if (cmd_i.is_idle)  state_d = ST_OUT;
          else if (new_ep)    state_d = ST_HYS;
          else                state_d = ST_EMA;
        end
      end
      ST_EMA:  state_d = ST_HYS;
      ST_HYS:  state_d = ST_DIV;
      ST_DIV:  if (step_q == StepW'(DivSteps - 1)) state_d = ST_OUT;
      ST_OUT:  if (res_ready_i) state_d = ST_WAIT;
      default: state_d = ST_WAIT;
    endcase
  end

  // control and tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_WAIT;
      ep_open_q    <= 1'b0;
      ep_ident_q   <= '0;
      ema_q        <= 16'sh8000;
      held_q       <= '1;
      frames_q     <= '0;
      known_q      <= '0;
      saved_q      <= '0;
      last_save_q  <= '0;
      saved_once_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_WAIT: begin
          if (pop_o) begin
            if (cmd_i.is_idle) begin
              ep_open_q <= 1'b0;
            end else if (new_ep) begin
              ep_open_q    <= 1'b1;
              ep_ident_q   <= cmd_i.lock_ident;
              ema_q        <= cmd_i.cand_score;
              held_q       <= '1;
              frames_q     <= '0;
              known_q      <= '0;
              saved_q      <= '0;
              saved_once_q <= 1'b0;
            end
          end
        end
        ST_EMA: ema_q <= ema_sat;
        ST_HYS: begin
          if (frames_q != CountMax) frames_q <= frames_q + 1'b1;
          held_q  <= held_next;
          known_q <= known_next;
          if (do_save) begin
            last_save_q  <= cur_q.stamp_ms;
            saved_once_q <= 1'b1;
            saved_q      <= saved_q + 6'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_WAIT: begin
        if (pop_o) begin
          cur_q <= cmd_i;
          if (cmd_i.is_idle) begin
            res_q <= idle_res;
          end
        end
      end
      ST_EMA: ;
      ST_HYS: begin
        save_now_q <= do_save;
        save_idx_q <= do_save ? saved_q : 6'd0;
        rem_q      <= {1'b0, known_next};
        step_q     <= '0;
        quo_q      <= '0;
      end
      ST_DIV: begin
        rem_q  <= rem_ge ? rem_sh - {1'b0, frames_q} : rem_sh;
        quo_q  <= {quo_q[DivSteps-2:0], rem_ge};
        step_q <= step_q + 1'b1;
        if (step_q == StepW'(DivSteps - 1)) begin
          res_q <= run_res;
        end
      end
      default: ;
    endcase
  end

  // multiplier feeding the smoothing step
  always_ff @(posedge clk_i) begin
    if (pop_o && !cmd_i.is_idle && !new_ep) begin
      prod_q <= $signed({1'b0, cfg_i.ema_weight}) *
                ($signed({cmd_i.cand_score[15], cmd_i.cand_score}) -
                 $signed({ema_q[15], ema_q}));
    end else if (state_q == ST_WAIT) begin
      prod_q <= '0;
    end
  end

endmodule

/* rtl/core/identity_hysteresis_tracker.sv */
// ----------------------------------------------------------------------------
// identity_hysteresis_tracker
// Per-frame identity tracker: smoothed score, two-threshold hysteresis,
// known-frame ratio and acquisition save throttle.
// ----------------------------------------------------------------------------
// sequence: an idle command goes from the queue straight to the result; a
//   run command on a new episode passes hysteresis and the divider, else
//   the smoothing step comes first; the back end takes one command at a
//   time through the 17-step serial stability divider; the front takes
//   requests while the two-entry queue has room and drops gated ones
// reset: asynchronous, active low; clears all tracking state and loads the
//   register defaults, no clearing pass
module identity_hysteresis_tracker import iht_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // locked, has_box, lock_age_ms[16], lock_ident[32], frame_ok, frame_seq[32],
  // embed_ok, cand_id[11], cand_score[16], stamp_ms[32], gallery_nonempty
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2], pred_id[11], smooth_score[16], frame_score[16], stability[16],
  // episode_lock[32], save_now, save_index[6], zero padding[4]
  output logic [103:0] m_axis_tdata
);

  cfg_t cfg_q;
  logic push, pop, full, empty, accept;
  cmd_t cmd_in, cmd_out;
  res_t res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.score_on       <= 16'sd11895;
      cfg_q.score_off      <= 16'sd9830;
      cfg_q.ema_weight     <= 16'd26214;
      cfg_q.stable_ms      <= 16'd2000;
      cfg_q.save_period_ms <= 16'd400;
      cfg_q.save_limit     <= 6'd40;
      cfg_q.run_mode       <= MODE_OFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SCORE_ON:    cfg_q.score_on       <= cfg_data_i;
        REG_SCORE_OFF:   cfg_q.score_off      <= cfg_data_i;
        REG_EMA_WEIGHT:  cfg_q.ema_weight     <= cfg_data_i;
        REG_STABLE_MS:   cfg_q.stable_ms      <= cfg_data_i;
        REG_SAVE_PERIOD: cfg_q.save_period_ms <= cfg_data_i;
        REG_SAVE_LIMIT:  cfg_q.save_limit     <= cfg_data_i[5:0];
        REG_RUN_MODE:    cfg_q.run_mode       <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  iht_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .accept_i           (accept),
    .locked_i           (s_axis_tdata[0]),
    .has_box_i          (s_axis_tdata[1]),
    .lock_age_ms_i      (s_axis_tdata[17:2]),
    .lock_ident_i       (s_axis_tdata[49:18]),
    .frame_ok_i         (s_axis_tdata[50]),
    .frame_seq_i        (s_axis_tdata[82:51]),
    .embed_ok_i         (s_axis_tdata[83]),
    .cand_id_i          (s_axis_tdata[94:84]),
    .cand_score_i       (s_axis_tdata[110:95]),
    .stamp_ms_i         (s_axis_tdata[142:111]),
    .gallery_nonempty_i (s_axis_tdata[143]),
    .push_o             (push),
    .cmd_o              (cmd_in)
  );

  iht_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .pop_i   (pop),
    .cmd_o   (cmd_out),
    .full_o  (full),
    .empty_o (empty)
  );

  iht_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // result packing
  assign m_axis_tdata = {4'b0, res.save_index, res.save_now, res.episode_lock,
                         res.stability, res.frame_score, res.smooth_score,
                         res.pred_id, res.status};

  // idle result carries no identity
  a_idle_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.status == STAT_IDLE |-> res.pred_id == -11'sd1 && !res.save_now)
    else $error("idle result with identity or save");

  // known status exactly when an identity is held
  a_status_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.status != STAT_IDLE |->
      ((res.status == STAT_KNOWN) == !res.pred_id[10]))
    else $error("status disagrees with predicted identity");

  // no save means a zero save index
  a_save_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res.save_now |-> res.save_index == 6'd0)
    else $error("save index without save");

  // the queue never overflows or underflows
  a_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full) && !(pop && empty))
    else $error("command queue overflow or underflow");

endmodule

/* sim/tracker_result_check.sv */
// ----------------------------------------------------------------------------
// tracker_result_check
// Watches the configuration port and both streams of the identity tracker,
// keeps its own copy of the tracking state, works out the result that each
// accepted request should give and compares every delivered result with it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tracker_result_check import iht_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  // locked, has_box, lock_age_ms[16], lock_ident[32], frame_ok, frame_seq[32],
  // embed_ok, cand_id[11], cand_score[16], stamp_ms[32], gallery_nonempty
  input  logic [143:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2], pred_id[11], smooth_score[16], frame_score[16], stability[16],
  // episode_lock[32], save_now, save_index[6], zero padding[4]
  input  logic [103:0] m_axis_tdata,
  output int           mismatch_count_o,
  output int           awaited_o
);

  localparam int PrintLimit = 100;

  // register copy
  cfg_t cfg;

  // tracking state copy
  logic                   idle_sent;
  logic [31:0]            last_seq;
  logic                   ep_open;
  logic [31:0]            ep_lock;
  logic signed [15:0]     ema;
  logic signed [10:0]     held;
  logic [CountBits-1:0]   frames;
  logic [CountBits-1:0]   knowns;
  logic [5:0]             saves;
  logic [31:0]            last_save;
  logic                   saved_any;

  // results still to come, oldest first
  res_t identity_reports_q[$];

  // one line per mismatch, printing stops after a while but counting goes on
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count_o++;
    if (mismatch_count_o <= PrintLimit)
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // track one update and queue the result it gives, if any
  task automatic advance_tracker(input logic [143:0] d);
    logic               locked, has_box, frame_ok, embed_ok, gallery;
    logic [15:0]        lock_age;
    logic [31:0]        ident, seq, stamp, elapsed;
    logic signed [10:0] cand;
    logic signed [15:0] score;
    logic               cand_ok;
    longint             mix, blended;
    logic [39:0]        ratio;
    res_t               r;
    locked   = d[0];
    has_box  = d[1];
    lock_age = d[17:2];
    ident    = d[49:18];
    frame_ok = d[50];
    seq      = d[82:51];
    embed_ok = d[83];
    cand     = d[94:84];
    score    = d[110:95];
    stamp    = d[142:111];
    gallery  = d[143];
    r = '0;

    // idle: report once, close the episode
    if (cfg.run_mode == MODE_OFF || cfg.run_mode == MODE_RSVD || !gallery) begin
      if (!idle_sent) begin
        ep_open   = 1'b0;
        idle_sent = 1'b1;
        r.status  = STAT_IDLE;
        r.pred_id = -11'sd1;
        identity_reports_q.push_back(r);
      end
      return;
    end
    idle_sent = 1'b0;

    // gating; the frame sequence is recorded before the embedding check
    if (!locked || !has_box || lock_age < cfg.stable_ms) return;
    if (!frame_ok || seq == last_seq) return;
    last_seq = seq;
    if (!embed_ok) return;

    cand_ok = (cand >= 0) && (cand < MaxIds);

    // new episode seeds the average, otherwise blend with rounding
    if (!ep_open || ident != ep_lock) begin
      ep_open   = 1'b1;
      ep_lock   = ident;
      ema       = score;
      held      = -11'sd1;
      frames    = '0;
      knowns    = '0;
      saves     = '0;
      saved_any = 1'b0;
    end else begin
      mix = longint'(cfg.ema_weight) * longint'(score) +
            (64'sd65536 - longint'(cfg.ema_weight)) * longint'(ema);
      blended = (mix + 64'sd32768) >>> 16;
      if (blended > 32767) ema = 16'sh7fff;
      else if (blended < -32768) ema = 16'sh8000;
      else ema = blended[15:0];
    end
    if (frames != {CountBits{1'b1}}) frames++;

    // two-threshold hysteresis
    if (held < 0) begin
      if (ema >= cfg.score_on && cand_ok) held = cand;
    end else if (cand_ok && cand == held) begin
      if (ema < cfg.score_off) held = -11'sd1;
    end else if (ema >= cfg.score_on && cand_ok) begin
      held = cand;
    end else if (ema < cfg.score_off) begin
      held = -11'sd1;
    end
    if (held >= 0 && knowns != {CountBits{1'b1}}) knowns++;

    // acquisition save throttle
    if (cfg.run_mode == MODE_ACQ && saves < cfg.save_limit) begin
      elapsed = stamp - last_save;
      if (!saved_any || elapsed >= 32'(cfg.save_period_ms)) begin
        last_save    = stamp;
        saved_any    = 1'b1;
        r.save_now   = 1'b1;
        r.save_index = saves;
        saves        = saves + 6'd1;
      end
    end

    ratio = {knowns, 16'h0000} / 40'(frames);
    r.status       = (held >= 0) ? STAT_KNOWN : STAT_UNKNOWN;
    r.pred_id      = held;
    r.smooth_score = ema;
    r.frame_score  = score;
    r.stability    = (ratio > 40'd65535) ? 16'hffff : ratio[15:0];
    r.episode_lock = ep_lock;
    identity_reports_q.push_back(r);
  endtask

  // compare a delivered result with the oldest one awaited
  task automatic check_report(input logic [103:0] d);
    res_t got, want;
    if (identity_reports_q.size() == 0) begin
      report_mismatch("result with none awaited", d[31:0], 32'd0);
      return;
    end
    want = identity_reports_q.pop_front();
    got.status       = d[1:0];
    got.pred_id      = d[12:2];
    got.smooth_score = d[28:13];
    got.frame_score  = d[44:29];
    got.stability    = d[60:45];
    got.episode_lock = d[92:61];
    got.save_now     = d[93];
    got.save_index   = d[99:94];
    if (got.status !== want.status)
      report_mismatch("status", 32'(got.status), 32'(want.status));
    if (got.pred_id !== want.pred_id)
      report_mismatch("pred_id", 32'(got.pred_id), 32'(want.pred_id));
    if (got.smooth_score !== want.smooth_score)
      report_mismatch("smooth_score", 32'(got.smooth_score), 32'(want.smooth_score));
    if (got.frame_score !== want.frame_score)
      report_mismatch("frame_score", 32'(got.frame_score), 32'(want.frame_score));
    if (got.stability !== want.stability)
      report_mismatch("stability", 32'(got.stability), 32'(want.stability));
    if (got.episode_lock !== want.episode_lock)
      report_mismatch("episode_lock", got.episode_lock, want.episode_lock);
    if (got.save_now !== want.save_now)
      report_mismatch("save_now", 32'(got.save_now), 32'(want.save_now));
    if (got.save_index !== want.save_index)
      report_mismatch("save_index", 32'(got.save_index), 32'(want.save_index));
    if (d[103:100] !== 4'h0)
      report_mismatch("padding", 32'(d[103:100]), 32'd0);
  endtask

  // sample everything at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.score_on       = 16'sd11895;
      cfg.score_off      = 16'sd9830;
      cfg.ema_weight     = 16'd26214;
      cfg.stable_ms      = 16'd2000;
      cfg.save_period_ms = 16'd400;
      cfg.save_limit     = 6'd40;
      cfg.run_mode       = MODE_OFF;
      idle_sent          = 1'b0;
      last_seq           = '0;
      ep_open            = 1'b0;
      ep_lock            = '0;
      ema                = 16'sh8000;
      held               = -11'sd1;
      frames             = '0;
      knowns             = '0;
      saves              = '0;
      last_save          = '0;
      saved_any          = 1'b0;
      mismatch_count_o   = 0;
      identity_reports_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SCORE_ON:    cfg.score_on       = cfg_data_i;
          REG_SCORE_OFF:   cfg.score_off      = cfg_data_i;
          REG_EMA_WEIGHT:  cfg.ema_weight     = cfg_data_i;
          REG_STABLE_MS:   cfg.stable_ms      = cfg_data_i;
          REG_SAVE_PERIOD: cfg.save_period_ms = cfg_data_i;
          REG_SAVE_LIMIT:  cfg.save_limit     = cfg_data_i[5:0];
          REG_RUN_MODE:    cfg.run_mode       = cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) check_report(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) advance_tracker(s_axis_tdata);
    end
    awaited_o = identity_reports_q.size();
  end

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives the identity tracker with a directed opening and random tracking
// updates over several register settings and idling patterns; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import iht_pkg::*;

  localparam int DrainCycles = 40;
  localparam int LongHold    = 300;
  localparam int PhaseCount  = 8;

  // one tracking update, laid out as the request data bus (last field lowest)
  typedef struct packed {
    logic               gallery_nonempty;
    logic [31:0]        stamp_ms;
    logic signed [15:0] cand_score;
    logic signed [10:0] cand_id;
    logic               embed_ok;
    logic [31:0]        frame_seq;
    logic               frame_ok;
    logic [31:0]        lock_ident;
    logic [15:0]        lock_age_ms;
    logic               has_box;
    logic               locked;
  } frame_update_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         cfg_we_i      = 1'b0;
  logic [2:0]   cfg_idx_i     = '0;
  logic [15:0]  cfg_data_i    = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;

  int mismatch_total;
  int awaited_total;

  // stimulus shaping state
  cfg_t               cfg_shadow;
  int                 send_idle_pct  = 0;
  int                 recv_stall_pct = 0;
  int                 hold_asks      = 0;
  int                 hold_seen      = 0;
  int                 hold_left      = 0;
  logic [31:0]        cur_ident, cur_seq, cur_stamp;
  logic signed [10:0] cur_cand;

  identity_hysteresis_tracker u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  tracker_result_check u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .mismatch_count_o (mismatch_total),
    .awaited_o        (awaited_total)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // result side: random stalls, plus a long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = LongHold;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic signed [15:0] clamp16(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // offer one request, with random gaps before it, until it is taken
  task automatic send_item(input frame_update_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // register write; the caller lowers the enable after the last one
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
  endtask

  task automatic apply_config(input cfg_t c);
    write_reg(REG_SCORE_ON, c.score_on);
    write_reg(REG_SCORE_OFF, c.score_off);
    write_reg(REG_EMA_WEIGHT, c.ema_weight);
    write_reg(REG_STABLE_MS, c.stable_ms);
    write_reg(REG_SAVE_PERIOD, c.save_period_ms);
    write_reg(REG_SAVE_LIMIT, 16'(c.save_limit));
    write_reg(REG_RUN_MODE, 16'(c.run_mode));
    cfg_we_i   <= 1'b0;
    cfg_shadow = c;
  endtask

  // all results in, then let gated requests clear the front end
  task automatic wait_drained();
    while (awaited_total != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // well-formed update on the current lock: stable, new frame, good embedding
  task automatic fresh_update(output frame_update_t it);
    cur_seq++;
    cur_stamp += $urandom_range(80, 10);
    it.locked           = 1'b1;
    it.has_box          = 1'b1;
    it.lock_age_ms      = 16'($urandom_range(65535, cfg_shadow.stable_ms));
    it.lock_ident       = cur_ident;
    it.frame_ok         = 1'b1;
    it.frame_seq        = cur_seq;
    it.embed_ok         = 1'b1;
    it.cand_id          = cur_cand;
    it.cand_score       = clamp16(int'(cfg_shadow.score_on) + 1500);
    it.stamp_ms         = cur_stamp;
    it.gallery_nonempty = 1'b1;
  endtask

  // mostly well-formed updates with random content, some noise
  task automatic next_random_update(output frame_update_t it);
    logic [159:0] raw;
    int           roll;
    fresh_update(it);
    if ($urandom_range(99) < 12) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
      it  = raw[143:0];
      return;
    end
    if ($urandom_range(99) < 6) begin
      cur_ident     = $urandom;
      it.lock_ident = cur_ident;
    end
    if ($urandom_range(99) < 4) begin
      cur_seq--;
      it.frame_seq = cur_seq;
    end
    if ($urandom_range(99) < 3) it.embed_ok = 1'b0;
    if ($urandom_range(99) < 2) it.gallery_nonempty = 1'b0;
    if ($urandom_range(99) < 3 && cfg_shadow.stable_ms != 0)
      it.lock_age_ms = 16'($urandom_range(cfg_shadow.stable_ms - 1, 0));

    // timestamps: small steps, some long gaps, now and then a jump anywhere
    roll = $urandom_range(99);
    if (roll < 10) cur_stamp += $urandom_range(1000);
    else if (roll < 12) cur_stamp = $urandom;
    it.stamp_ms = cur_stamp;

    // candidate: mostly the current person, sometimes another, none or an edge id
    roll = $urandom_range(99);
    if (roll < 15) begin
      it.cand_id = 11'($urandom_range(1023));
      if ($urandom_range(2) == 0) cur_cand = it.cand_id;
    end else if (roll < 27) begin
      it.cand_id = -11'sd1;
    end else if (roll < 31) begin
      it.cand_id = ($urandom_range(1) != 0) ? 11'sd1023 : 11'sd0;
    end

    // score: around either threshold, or anywhere
    roll = $urandom_range(99);
    if (roll < 45)
      it.cand_score = clamp16(int'(cfg_shadow.score_on) + int'($urandom_range(8000)) - 4000);
    else if (roll < 75)
      it.cand_score = clamp16(int'(cfg_shadow.score_off) + int'($urandom_range(8000)) - 4000);
    else
      it.cand_score = 16'($urandom);
  endtask

  initial begin
    frame_update_t it;
    cfg_t          c;
    int            phase_len;

    cfg_shadow.score_on       = 16'sd11895;
    cfg_shadow.score_off      = 16'sd9830;
    cfg_shadow.ema_weight     = 16'd26214;
    cfg_shadow.stable_ms      = 16'd2000;
    cfg_shadow.save_period_ms = 16'd400;
    cfg_shadow.save_limit     = 6'd40;
    cfg_shadow.run_mode       = MODE_OFF;
    cur_ident = $urandom;
    cur_seq   = $urandom;
    cur_stamp = $urandom;
    cur_cand  = 11'sd7;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // mode off after reset: one idle result, then silence
    fresh_update(it);
    send_item(it);
    fresh_update(it);
    send_item(it);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    c = cfg_shadow;
    c.run_mode = MODE_REC;
    apply_config(c);

    // new episode commits at once on a high seed
    fresh_update(it);
    it.cand_score = 16'sd20000;
    send_item(it);
    // same frame again is dropped
    send_item(it);
    // lock too young, no lock, no box, bad frame, failed embedding
    fresh_update(it);
    it.lock_age_ms = cfg_shadow.stable_ms - 16'd1;
    send_item(it);
    fresh_update(it);
    it.locked = 1'b0;
    send_item(it);
    fresh_update(it);
    it.has_box = 1'b0;
    send_item(it);
    fresh_update(it);
    it.frame_ok = 1'b0;
    send_item(it);
    fresh_update(it);
    it.embed_ok = 1'b0;
    send_item(it);
    // score extremes, no candidate drags the average down and releases
    fresh_update(it);
    it.cand_score = 16'sh7fff;
    send_item(it);
    fresh_update(it);
    it.cand_id    = -11'sd1;
    it.cand_score = 16'sh8000;
    send_item(it);
    // highest id gets committed, then a switch to id zero
    repeat (3) begin
      fresh_update(it);
      it.cand_id    = 11'sd1023;
      it.cand_score = 16'sh7fff;
      send_item(it);
    end
    fresh_update(it);
    it.cand_id    = 11'sd0;
    it.cand_score = 16'sh7fff;
    send_item(it);
    // the held id itself scores low and is released
    repeat (2) begin
      fresh_update(it);
      it.cand_id    = 11'sd0;
      it.cand_score = 16'sh8000;
      send_item(it);
    end
    // empty gallery: idle once, closing the episode
    repeat (2) begin
      fresh_update(it);
      it.gallery_nonempty = 1'b0;
      send_item(it);
    end
    // same lock reopens an episode, then a lock change opens another
    fresh_update(it);
    send_item(it);
    cur_ident++;
    fresh_update(it);
    send_item(it);
    fresh_update(it);
    it.lock_age_ms = 16'hffff;
    send_item(it);

    // random phases over register settings and idling patterns
    for (int p = 0; p < PhaseCount; p++) begin
      s_axis_tvalid <= 1'b0;
      wait_drained();
      c = cfg_shadow;
      case (p)
        0: c.run_mode = MODE_ACQ;
        1: begin
          c.score_on       = 16'sh7fff;
          c.score_off      = 16'sh8000;
          c.ema_weight     = 16'h0000;
          c.stable_ms      = 16'h0000;
          c.save_period_ms = 16'h0000;
          c.save_limit     = 6'd63;
          c.run_mode       = MODE_ACQ;
        end
        2: begin
          c.score_on       = 16'sh8000;
          c.score_off      = 16'sh7fff;
          c.ema_weight     = 16'hffff;
          c.stable_ms      = 16'hffff;
          c.save_period_ms = 16'hffff;
          c.save_limit     = 6'd0;
          c.run_mode       = MODE_REC;
        end
        3: c.run_mode = MODE_RSVD;
        default: begin
          c.score_on       = clamp16(int'($urandom_range(20000, 4000)));
          c.score_off      = clamp16(int'(c.score_on) - int'($urandom_range(6000)));
          c.ema_weight     = 16'($urandom);
          c.stable_ms      = 16'($urandom_range(3000));
          c.save_period_ms = 16'($urandom_range(600));
          c.save_limit     = 6'($urandom_range(63));
          c.run_mode       = ($urandom_range(1) != 0) ? MODE_ACQ : MODE_REC;
        end
      endcase
      apply_config(c);

      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 53;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 53;
        end
        default: begin
          send_idle_pct  = 34;
          recv_stall_pct = 34;
        end
      endcase

      // result side holds off while requests keep coming, filling the block
      if (p == 4) hold_asks++;
      phase_len = (p == 3) ? 15 : 65;
      for (int n = 0; n < phase_len; n++) begin
        // request side pauses until every result is back
        if (p == 5 && n == 35) begin
          s_axis_tvalid <= 1'b0;
          @(negedge clk_i);
          while (awaited_total != 0) @(negedge clk_i);
        end
        next_random_update(it);
        send_item(it);
      end
    end

    // drain and verdict
    s_axis_tvalid <= 1'b0;
    wait_drained();
    if (mismatch_total == 0 && awaited_total == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
